FILE: rtl/dsas_pkg.sv
// ----------------------------------------------------------------------------
// dsas_pkg
// Shared types and constants for the dual sensor average steering block.
// ----------------------------------------------------------------------------
package dsas_pkg;

  // Ring geometry and decision constants.
  localparam int RING_DEPTH  = 10;
  localparam int WINDOW      = 5;
  localparam int BUCKET_STEP = 40;

  localparam int SAMPLE_W = 8;
  localparam int AVG_W    = 8;
  localparam int BUCKET_W = 8;

  // A window sum holds at most WINDOW full-scale samples.
  localparam int SUM_W = $clog2(((1 << SAMPLE_W) - 1) * WINDOW + 1);

  // Exact division by a constant: q = (n * MULT) >> SHIFT for every n below
  // 2**N when SHIFT = N + ceil(log2(d)) and MULT = ceil(2**SHIFT / d).
  localparam int AVG_SHIFT  = SUM_W + $clog2(WINDOW);
  localparam int AVG_MULT   = ((1 << AVG_SHIFT) + WINDOW - 1) / WINDOW;
  localparam int AVG_MULT_W = AVG_SHIFT + 1;
  localparam int AVG_PROD_W = SUM_W + AVG_MULT_W;

  localparam int BKT_SHIFT  = AVG_W + $clog2(BUCKET_STEP);
  localparam int BKT_MULT   = ((1 << BKT_SHIFT) + BUCKET_STEP - 1) / BUCKET_STEP;
  localparam int BKT_MULT_W = BKT_SHIFT + 1;
  localparam int BKT_PROD_W = AVG_W + BKT_MULT_W;

  // Item kinds on the input tuser bit.
  localparam logic FUNC_STORE = 1'b0;
  localparam logic FUNC_EVAL  = 1'b1;

  // Drive decisions and their motor port bytes.
  typedef enum logic [1:0] {
    DRIVE_STOP    = 2'd0,
    DRIVE_RIGHT   = 2'd1,
    DRIVE_LEFT    = 2'd2,
    DRIVE_FORWARD = 2'd3
  } drive_t;

  localparam logic [7:0] PATTERN_STOP    = 8'h0F;
  localparam logic [7:0] PATTERN_RIGHT   = 8'h0D;
  localparam logic [7:0] PATTERN_LEFT    = 8'h07;
  localparam logic [7:0] PATTERN_FORWARD = 8'h05;

  // Configuration register map.
  localparam int              CFG_ADDR_W      = 3;
  localparam int              CFG_INDEX_W     = CFG_ADDR_W - 2;
  localparam logic [CFG_INDEX_W-1:0] REG_STOP_THRESHOLD = '0;
  localparam logic [7:0]      STOP_THRESHOLD_RESET = 8'd200;

  // Window sums handed from the ring stage to the decision stages.
  typedef struct packed {
    logic             vld;
    logic [SUM_W-1:0] sum_a;
    logic [SUM_W-1:0] sum_b;
  } sum_stage_t;

  // Finished result item.
  typedef struct packed {
    logic             vld;
    drive_t           drive_code;
    logic [7:0]       port_pattern;
    logic [AVG_W-1:0] average_a;
    logic [AVG_W-1:0] average_b;
  } result_t;

endpackage

FILE: rtl/dsas_cfg.sv
// ----------------------------------------------------------------------------
// dsas_cfg
// APB register file holding the stop threshold.
// ----------------------------------------------------------------------------
module dsas_cfg (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [dsas_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [31:0]                    pwdata,
  output logic [31:0]                    prdata,
  output logic                           pready,
  output logic [7:0]                     stop_threshold
);
  import dsas_pkg::*;

  logic [CFG_INDEX_W-1:0] reg_index;
  logic                   wr_en;

  assign reg_index = paddr[CFG_ADDR_W-1:2];
  assign pready    = 1'b1;
  assign wr_en     = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      stop_threshold <= STOP_THRESHOLD_RESET;
    end else if (wr_en && (reg_index == REG_STOP_THRESHOLD)) begin
      stop_threshold <= pwdata[7:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (reg_index == REG_STOP_THRESHOLD) begin
      prdata = {24'd0, stop_threshold};
    end
  end

endmodule

FILE: rtl/dsas_window.sv
// ----------------------------------------------------------------------------
// dsas_window
// Input register, age-ordered sample lines for both sensors and the
// registered window sums.
// ----------------------------------------------------------------------------
module dsas_window (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         s_tvalid,
  output logic                         s_tready,
  input  logic                         func,
  input  logic [dsas_pkg::SAMPLE_W-1:0] sample_a,
  input  logic [dsas_pkg::SAMPLE_W-1:0] sample_b,
  output dsas_pkg::sum_stage_t         sums,
  input  logic                         sums_ready
);
  import dsas_pkg::*;

  // Held request.
  logic                in_vld;
  logic                in_func;
  logic [SAMPLE_W-1:0] in_a;
  logic [SAMPLE_W-1:0] in_b;

  // Sample lines: entry 0 is the oldest sample, the last entry the newest.
  // This is the ring read from its write pointer onward.
  logic [SAMPLE_W-1:0] line_a [RING_DEPTH];
  logic [SAMPLE_W-1:0] line_b [RING_DEPTH];

  logic             go;
  logic             store_go;
  logic             eval_go;
  logic             slot_free;
  logic [SUM_W-1:0] sum_a_next;
  logic [SUM_W-1:0] sum_b_next;

  // A store needs no downstream slot; an evaluate needs the sum register.
  assign slot_free = !sums.vld || sums_ready;
  assign go        = in_vld && ((in_func == FUNC_STORE) || slot_free);
  assign store_go  = go && (in_func == FUNC_STORE);
  assign eval_go   = go && (in_func == FUNC_EVAL);
  assign s_tready  = !in_vld || go;

  always_comb begin
    sum_a_next = '0;
    sum_b_next = '0;
    for (int k = 0; k < WINDOW; k++) begin
      sum_a_next = sum_a_next + SUM_W'(line_a[k]);
      sum_b_next = sum_b_next + SUM_W'(line_b[k]);
    end
  end

  // Valid bits are reset; the data beside them is only loaded.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_vld   <= 1'b0;
      sums.vld <= 1'b0;
    end else begin
      if (s_tready) begin
        in_vld <= s_tvalid;
      end
      if (slot_free) begin
        sums.vld <= eval_go;
      end
    end
    if (s_tvalid && s_tready) begin
      in_func <= func;
      in_a    <= sample_a;
      in_b    <= sample_b;
    end
    if (eval_go) begin
      sums.sum_a <= sum_a_next;
      sums.sum_b <= sum_b_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < RING_DEPTH; k++) begin
        line_a[k] <= '0;
        line_b[k] <= '0;
      end
    end else if (store_go) begin
      for (int k = 0; k < RING_DEPTH - 1; k++) begin
        line_a[k] <= line_a[k+1];
        line_b[k] <= line_b[k+1];
      end
      line_a[RING_DEPTH-1] <= in_a;
      line_b[RING_DEPTH-1] <= in_b;
    end
  end

endmodule

FILE: rtl/dsas_decide.sv
// ----------------------------------------------------------------------------
// dsas_decide
// Average stage (divide by the window length) and decision stage (bucket
// compare and stop test) ending in the result register.
// ----------------------------------------------------------------------------
module dsas_decide (
  input  logic                 clk,
  input  logic                 rst,
  input  dsas_pkg::sum_stage_t sums,
  output logic                 sums_ready,
  input  logic [7:0]           stop_threshold,
  output dsas_pkg::result_t    result,
  input  logic                 m_tready
);
  import dsas_pkg::*;

  logic             avg_vld;
  logic [AVG_W-1:0] avg_a;
  logic [AVG_W-1:0] avg_b;

  logic                  out_free;
  logic [AVG_PROD_W-1:0] prod_a;
  logic [AVG_PROD_W-1:0] prod_b;
  logic [BKT_PROD_W-1:0] bprod_a;
  logic [BKT_PROD_W-1:0] bprod_b;
  logic [BUCKET_W-1:0]   bucket_a;
  logic [BUCKET_W-1:0]   bucket_b;
  drive_t                code_next;
  logic [7:0]            pattern_next;

  assign out_free   = !result.vld || m_tready;
  assign sums_ready = !avg_vld || out_free;

  assign prod_a = AVG_PROD_W'(sums.sum_a) * AVG_PROD_W'(AVG_MULT_W'(AVG_MULT));
  assign prod_b = AVG_PROD_W'(sums.sum_b) * AVG_PROD_W'(AVG_MULT_W'(AVG_MULT));

  assign bprod_a  = BKT_PROD_W'(avg_a) * BKT_PROD_W'(BKT_MULT_W'(BKT_MULT));
  assign bprod_b  = BKT_PROD_W'(avg_b) * BKT_PROD_W'(BKT_MULT_W'(BKT_MULT));
  assign bucket_a = bprod_a[BKT_SHIFT +: BUCKET_W];
  assign bucket_b = bprod_b[BKT_SHIFT +: BUCKET_W];

  always_comb begin
    if ((avg_a > stop_threshold) && (avg_b > stop_threshold)) begin
      code_next = DRIVE_STOP;
    end else if (bucket_a > bucket_b) begin
      code_next = DRIVE_RIGHT;
    end else if (bucket_a < bucket_b) begin
      code_next = DRIVE_LEFT;
    end else begin
      code_next = DRIVE_FORWARD;
    end
  end

  always_comb begin
    case (code_next)
      DRIVE_STOP:    pattern_next = PATTERN_STOP;
      DRIVE_RIGHT:   pattern_next = PATTERN_RIGHT;
      DRIVE_LEFT:    pattern_next = PATTERN_LEFT;
      DRIVE_FORWARD: pattern_next = PATTERN_FORWARD;
      default:       pattern_next = PATTERN_STOP;
    endcase
  end

  // Valid bits are reset; the data beside them is only loaded.
  always_ff @(posedge clk) begin
    if (rst) begin
      avg_vld    <= 1'b0;
      result.vld <= 1'b0;
    end else begin
      if (sums_ready) begin
        avg_vld <= sums.vld;
      end
      if (out_free) begin
        result.vld <= avg_vld;
      end
    end
    if (sums_ready && sums.vld) begin
      avg_a <= prod_a[AVG_SHIFT +: AVG_W];
      avg_b <= prod_b[AVG_SHIFT +: AVG_W];
    end
    if (out_free && avg_vld) begin
      result.drive_code   <= code_next;
      result.port_pattern <= pattern_next;
      result.average_a    <= avg_a;
      result.average_b    <= avg_b;
    end
  end

endmodule

FILE: rtl/dual_sensor_average_steering.sv
// ----------------------------------------------------------------------------
// dual_sensor_average_steering
// Keeps the recent samples of two line sensors and turns the average of the
// oldest window into a steering decision.
// ----------------------------------------------------------------------------
//
//   channel   direction  handshake              contents
//   s_*       in         s_tvalid / s_tready    request: tuser kind, tdata samples
//   m_*       out        m_tvalid / m_tready    decision code, port byte, averages
//   APB       in         psel/penable/pready    stop threshold register
//
// A new request is accepted in every cycle while the pipeline moves. An
// evaluate request passes from the input register to the window sum
// register, through the average divide, then through the bucket compare into
// the result register. A store request gives no result and leaves the
// pipeline from the input register. Reset (synchronous, active high) clears
// the sample lines to zero and the threshold to 200; it needs no clearing
// pass. A stall on m_tready fills the stages one by one, and s_tready falls
// only when the input register cannot move on.
//
// The ring and its wrapping write pointer are held as two shift lines in age
// order: entry 0 is the sample the pointer would overwrite next. A store
// shifts every entry one place toward the old end and puts the new sample at
// the young end, so the evaluate window is always the first WINDOW taps.
// Both divisions are by constants and use exact reciprocal multiplies, each
// in a stage of its own.
// ----------------------------------------------------------------------------
module dual_sensor_average_steering (
  input  logic                            clk,
  input  logic                            rst,
  // Input stream.
  input  logic                            s_tvalid,
  output logic                            s_tready,
  input  logic [15:0]                     s_tdata,  // sample_a[7:0], sample_b[15:8]
  input  logic [0:0]                      s_tuser,  // func[0]
  // Output stream.
  output logic                            m_tvalid,
  input  logic                            m_tready,
  // drive_code[1:0], port_pattern[9:2], average_a[17:10], average_b[25:18],
  // zero fill [31:26]
  output logic [31:0]                     m_tdata,
  // Configuration port.
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [dsas_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [31:0]                     pwdata,
  output logic [31:0]                     prdata,
  output logic                            pready
);
  import dsas_pkg::*;

  logic [7:0] stop_threshold;
  sum_stage_t sums;
  logic       sums_ready;
  result_t    result;

  dsas_cfg u_cfg (
    .clk            (clk),
    .rst            (rst),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready),
    .stop_threshold (stop_threshold)
  );

  dsas_window u_window (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .func       (s_tuser[0]),
    .sample_a   (s_tdata[7:0]),
    .sample_b   (s_tdata[15:8]),
    .sums       (sums),
    .sums_ready (sums_ready)
  );

  dsas_decide u_decide (
    .clk            (clk),
    .rst            (rst),
    .sums           (sums),
    .sums_ready     (sums_ready),
    .stop_threshold (stop_threshold),
    .result         (result),
    .m_tready       (m_tready)
  );

  // The result register drives the output stream directly.
  assign m_tvalid = result.vld;
  assign m_tdata  = {6'd0, result.average_b, result.average_a,
                     result.port_pattern, result.drive_code};

endmodule

FILE: rtl/dsas_checker.sv
// ----------------------------------------------------------------------------
// dsas_checker
// Port-level checks of the steering block, bound to the top level.
// ----------------------------------------------------------------------------
module dsas_checker (
  input logic        clk,
  input logic        rst,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [31:0] m_tdata,
  input logic        pready
);
  import dsas_pkg::*;

  logic [1:0] code;
  logic [7:0] pattern;
  logic [7:0] avg_a;
  logic [7:0] avg_b;

  assign code    = m_tdata[1:0];
  assign pattern = m_tdata[9:2];
  assign avg_a   = m_tdata[17:10];
  assign avg_b   = m_tdata[25:18];

  // A stalled result holds its value.
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("stalled result changed");

  // The port byte always matches the decision code.
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (code == DRIVE_STOP    && pattern == PATTERN_STOP)  ||
                 (code == DRIVE_RIGHT   && pattern == PATTERN_RIGHT) ||
                 (code == DRIVE_LEFT    && pattern == PATTERN_LEFT)  ||
                 (code == DRIVE_FORWARD && pattern == PATTERN_FORWARD))
    else $error("port pattern does not match drive code");

  // Stop needs both averages strictly above a threshold, so neither is zero.
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && code == DRIVE_STOP |-> avg_a != 8'd0 && avg_b != 8'd0)
    else $error("stop decision with a zero average");

  // No result is offered right after reset.
  assert property (@(posedge clk) $past(rst) |-> !m_tvalid)
    else $error("result valid after reset");

  // The register port never inserts wait states.
  assert property (@(posedge clk) disable iff (rst) pready)
    else $error("pready low");

endmodule

bind dual_sensor_average_steering dsas_checker u_dsas_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .pready   (pready)
);

FILE: tb/sv/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking testbench for dual_sensor_average_steering. A driver feeds
// store and evaluate requests from a queue over the input stream, a monitor
// predicts every steering decision from its own copy of the sample rings and
// checks each decision that leaves the output stream. The stop threshold is
// rewritten over the APB port between phases, and the sender and receiver idle
// at random with one of four idle patterns per phase, taken in turn.
// ----------------------------------------------------------------------------
module tb;
  import dsas_pkg::*;

  // Cycles waited for a request to leave the pipeline. A store gives no result,
  // so a drained result queue does not prove that the block is idle.
  localparam int PIPE_SETTLE = 8;

  // The slowest correct run is roughly 1100 requests under the heaviest
  // idling, plus the drains. The limit is many times that.
  localparam int CYCLE_LIMIT = 400000;

  // Only the first mismatches are printed; the rest are counted.
  localparam int MAX_REPORTS = 40;

  localparam int RANDOM_PHASES    = 6;
  localparam int ITEMS_PER_PHASE  = 175;

  // Bits of a ring slot number.
  localparam int SLOT_W = $clog2(RING_DEPTH);

  // Byte addresses on the configuration port. Index 1 has no register.
  localparam logic [CFG_ADDR_W-1:0] ADDR_THRESHOLD = {REG_STOP_THRESHOLD, 2'b00};
  localparam logic [CFG_ADDR_W-1:0] ADDR_SPARE     = 3'b100;

  // Idle patterns, one per phase.
  typedef enum int {
    IDLE_NONE,
    IDLE_SENDER,
    IDLE_RECEIVER,
    IDLE_BOTH
  } idle_mode_t;

  // One request on the input stream.
  typedef struct packed {
    logic       func;
    logic [7:0] sample_a;
    logic [7:0] sample_b;
  } sensor_req_t;

  // One steering decision as it should appear on the output stream.
  typedef struct packed {
    drive_t     drive_code;
    logic [7:0] port_pattern;
    logic [7:0] average_a;
    logic [7:0] average_b;
  } steer_result_t;

  // Clock and reset.
  logic clk = 1'b0;
  logic rst = 1'b1;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Block ports, every input at a known value from time zero.
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [15:0]           s_tdata  = '0;
  logic [0:0]            s_tuser  = '0;
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [31:0]           m_tdata;
  logic                  psel     = 1'b0;
  logic                  penable  = 1'b0;
  logic                  pwrite   = 1'b0;
  logic [CFG_ADDR_W-1:0] paddr    = '0;
  logic [31:0]           pwdata   = '0;
  logic [31:0]           prdata;
  logic                  pready;

  dual_sensor_average_steering dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  // Requests waiting to be driven and decisions waiting to come out.
  sensor_req_t   pending_requests[$];
  steer_result_t decision_fifo[$];

  // The predictor's copy of the block state: the two sample rings, the
  // shared write slot, and the stop threshold.
  logic [7:0]  line_a [RING_DEPTH];
  logic [7:0]  line_b [RING_DEPTH];
  int unsigned wr_slot;
  logic [7:0]  stop_level;

  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;
  logic        req_taken      = 1'b0;
  sensor_req_t drv_req;

  int unsigned cycle_count    = 0;
  int unsigned mismatch_count = 0;
  int unsigned store_count    = 0;
  int unsigned eval_count     = 0;
  int unsigned result_count   = 0;
  int unsigned drive_hits [4] = '{0, 0, 0, 0};
  int unsigned level_writes   = 0;

  initial begin
    for (int k = 0; k < RING_DEPTH; k++) begin
      line_a[k] = '0;
      line_b[k] = '0;
    end
    wr_slot    = 0;
    stop_level = STOP_THRESHOLD_RESET;
  end

  // Prints one line per mismatch (up to a cap) and counts every one.
  task automatic report_mismatch(input string what, input int unsigned got,
                                 input int unsigned want);
    mismatch_count++;
    if (mismatch_count <= MAX_REPORTS) begin
      $display("MISMATCH %s: got %0d, expected %0d (decision %0d, cycle %0d)",
               what, got, want, result_count, cycle_count);
    end
  endtask

  // Averages the oldest WINDOW entries of each ring, starting at the write
  // slot and wrapping at the ring end, and turns them into a decision. Stop
  // needs both averages strictly above the threshold; otherwise the coarse
  // buckets of the two channels are compared.
  function automatic steer_result_t steer_decision();
    int unsigned   sum_a;
    int unsigned   sum_b;
    int unsigned   avg_a;
    int unsigned   avg_b;
    int unsigned   bkt_a;
    int unsigned   bkt_b;
    steer_result_t r;
    sum_a = 0;
    sum_b = 0;
    for (int k = 0; k < WINDOW; k++) begin
      sum_a += line_a[SLOT_W'((wr_slot + k) % RING_DEPTH)];
      sum_b += line_b[SLOT_W'((wr_slot + k) % RING_DEPTH)];
    end
    avg_a = sum_a / WINDOW;
    avg_b = sum_b / WINDOW;
    bkt_a = avg_a / BUCKET_STEP;
    bkt_b = avg_b / BUCKET_STEP;
    if (avg_a > stop_level && avg_b > stop_level) begin
      r.drive_code   = DRIVE_STOP;
      r.port_pattern = PATTERN_STOP;
    end else if (bkt_a > bkt_b) begin
      r.drive_code   = DRIVE_RIGHT;
      r.port_pattern = PATTERN_RIGHT;
    end else if (bkt_a < bkt_b) begin
      r.drive_code   = DRIVE_LEFT;
      r.port_pattern = PATTERN_LEFT;
    end else begin
      r.drive_code   = DRIVE_FORWARD;
      r.port_pattern = PATTERN_FORWARD;
    end
    r.average_a = avg_a[7:0];
    r.average_b = avg_b[7:0];
    return r;
  endfunction

  // Driver. A request stays on the bus until it is taken; a new one is put
  // up in the same step the old one leaves, so tvalid is assigned only once
  // per falling edge.
  always @(negedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else if (!s_tvalid || req_taken) begin
      if (pending_requests.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        drv_req = pending_requests.pop_front();
        s_tvalid <= 1'b1;
        s_tuser  <= drv_req.func;
        s_tdata  <= {drv_req.sample_b, drv_req.sample_a};
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // Receiver back-pressure, drawn anew every cycle.
  always @(negedge clk) begin
    m_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Monitor. Every accepted request runs through the predictor in order, and
  // every accepted decision is checked against the oldest prediction.
  always @(posedge clk) begin : monitor
    steer_result_t want;
    if (rst) begin
      req_taken <= 1'b0;
    end else begin
      req_taken <= s_tvalid && s_tready;
      if (s_tvalid && s_tready) begin
        if (s_tuser[0] == FUNC_STORE) begin
          line_a[SLOT_W'(wr_slot)] = s_tdata[7:0];
          line_b[SLOT_W'(wr_slot)] = s_tdata[15:8];
          wr_slot = (wr_slot + 1) % RING_DEPTH;
          store_count++;
        end else begin
          decision_fifo.push_back(steer_decision());
          eval_count++;
        end
      end
      if (m_tvalid && m_tready) begin
        result_count++;
        if (decision_fifo.size() == 0) begin
          report_mismatch("decision with none pending", 1, 0);
        end else begin
          want = decision_fifo.pop_front();
          drive_hits[want.drive_code]++;
          if (m_tdata[1:0] != want.drive_code)
            report_mismatch("drive_code", 32'(m_tdata[1:0]), 32'(want.drive_code));
          if (m_tdata[9:2] != want.port_pattern)
            report_mismatch("port_pattern", 32'(m_tdata[9:2]), 32'(want.port_pattern));
          if (m_tdata[17:10] != want.average_a)
            report_mismatch("average_a", 32'(m_tdata[17:10]), 32'(want.average_a));
          if (m_tdata[25:18] != want.average_b)
            report_mismatch("average_b", 32'(m_tdata[25:18]), 32'(want.average_b));
        end
      end
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d decisions still pending",
               cycle_count, decision_fifo.size());
      $display("Simulation FAILED");
      $finish;
    end
  end

  function automatic void push_req(input logic func, input logic [7:0] a,
                                   input logic [7:0] b);
    sensor_req_t r;
    r.func     = func;
    r.sample_a = a;
    r.sample_b = b;
    pending_requests.push_back(r);
  endfunction

  // A sample scattered around a base value, clipped to the 8-bit range.
  function automatic logic [7:0] near(input int base, input int spread);
    int v;
    v = base + int'($urandom_range(2 * spread)) - spread;
    if (v < 0) v = 0;
    if (v > 255) v = 255;
    return v[7:0];
  endfunction

  // Queues one burst of traffic and returns how many requests it added.
  // Most bursts are stores around a random level per channel followed by an
  // evaluate, so that every decision and both sides of every bucket show up.
  // Some fill the ring with values at or just above the threshold, some are
  // evaluate runs or random stores and an evaluate, or lone random requests.
  function automatic int queue_burst(input logic [7:0] level);
    int         kind;
    int         n;
    int         base_a;
    int         base_b;
    int         spread;
    logic [7:0] va;
    logic [7:0] vb;
    kind = $urandom_range(9);
    case (kind)
      6: begin
        va = (level == 8'd255 || $urandom_range(1) == 0) ? level : level + 8'd1;
        vb = (level == 8'd255 || $urandom_range(1) == 0) ? level : level + 8'd1;
        for (int k = 0; k < RING_DEPTH; k++) push_req(FUNC_STORE, va, vb);
        push_req(FUNC_EVAL, 8'($urandom_range(255)), 8'($urandom_range(255)));
        return RING_DEPTH + 1;
      end
      7: begin
        push_req($urandom_range(1) ? FUNC_EVAL : FUNC_STORE,
                 8'($urandom_range(255)), 8'($urandom_range(255)));
        return 1;
      end
      8: begin
        n = $urandom_range(2, 3);
        for (int k = 0; k < n; k++) begin
          push_req(FUNC_EVAL, 8'($urandom_range(255)), 8'($urandom_range(255)));
        end
        return n;
      end
      9: begin
        n = $urandom_range(1, 12);
        for (int k = 0; k < n; k++) begin
          push_req(FUNC_STORE, 8'($urandom_range(255)), 8'($urandom_range(255)));
        end
        push_req(FUNC_EVAL, 8'($urandom_range(255)), 8'($urandom_range(255)));
        return n + 1;
      end
      default: begin
        base_a = $urandom_range(255);
        base_b = $urandom_range(1) ? base_a : int'($urandom_range(255));
        spread = $urandom_range(40);
        n      = $urandom_range(1, 8);
        for (int k = 0; k < n; k++) begin
          push_req(FUNC_STORE, near(base_a, spread), near(base_b, spread));
        end
        push_req(FUNC_EVAL, 8'($urandom_range(255)), 8'($urandom_range(255)));
        return n + 1;
      end
    endcase
  endfunction

  // Waits until every request has gone in and every decision has come out,
  // then lets the pipeline empty of stores that give no decision.
  task automatic wait_quiet();
    while (pending_requests.size() != 0 || s_tvalid || decision_fifo.size() != 0) begin
      @(posedge clk);
    end
    repeat (PIPE_SETTLE) @(posedge clk);
  endtask

  // APB write: a setup cycle, then an access cycle held until pready.
  task automatic apb_write(input logic [CFG_ADDR_W-1:0] addr, input logic [31:0] data);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (addr == ADDR_THRESHOLD) begin
      stop_level = data[7:0];
      level_writes++;
    end
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // APB read of the threshold register, checked against the predictor.
  task automatic check_threshold_reg();
    logic [31:0] rd;
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= ADDR_THRESHOLD;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    rd = prdata;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    if (rd[7:0] != stop_level)
      report_mismatch("stop_threshold readback", 32'(rd[7:0]), 32'(stop_level));
  endtask

  function automatic void set_idle(input idle_mode_t mode);
    send_idle_pct  = (mode == IDLE_SENDER)   ? 59 : (mode == IDLE_BOTH) ? 38 : 0;
    recv_stall_pct = (mode == IDLE_RECEIVER) ? 59 : (mode == IDLE_BOTH) ? 38 : 0;
  endfunction

  // Stimulus and end of run.
  initial begin : stimulus
    int         level_plan [RANDOM_PHASES];
    logic [7:0] level;
    int         pushed;
    bit         drained;

    level_plan = '{0, 255, -1, 1, -1, 200};

    repeat (4) @(negedge clk);
    rst <= 1'b0;

    // Directed part at the reset threshold. An evaluate right after reset
    // sees an all-zero window. Ten stores then give a window of full-scale
    // first-channel samples (right), five more move the window onto the
    // full-scale second channel (left), three more make the window wrap past
    // the ring end, and two more leave a full-scale window on both (stop).
    // Some evaluates carry nonzero samples, which must be ignored.
    push_req(FUNC_EVAL, 8'd255, 8'd255);
    for (int k = 0; k < 5; k++) push_req(FUNC_STORE, 8'd255, 8'd0);
    for (int k = 0; k < 5; k++) push_req(FUNC_STORE, 8'd0, 8'd255);
    push_req(FUNC_EVAL, 8'd0, 8'd0);
    for (int k = 0; k < 5; k++) push_req(FUNC_STORE, 8'd255, 8'd255);
    push_req(FUNC_EVAL, 8'd0, 8'd255);
    for (int k = 0; k < 3; k++) push_req(FUNC_STORE, 8'd255, 8'd255);
    push_req(FUNC_EVAL, 8'd255, 8'd0);
    for (int k = 0; k < 2; k++) push_req(FUNC_STORE, 8'd255, 8'd255);
    push_req(FUNC_EVAL, 8'd0, 8'd0);
    wait_quiet();
    check_threshold_reg();

    // Random phases, each with its own threshold and idle pattern.
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      level = (level_plan[p] < 0) ? 8'($urandom_range(255)) : 8'(level_plan[p]);
      apb_write(ADDR_THRESHOLD, {16'($urandom_range(16'hFFFF)), 8'($urandom_range(255)),
                                 level});
      if (p == 2) begin
        // A write to an address with no register must change nothing.
        apb_write(ADDR_SPARE, $urandom());
      end
      check_threshold_reg();
      set_idle(idle_mode_t'(p % 4));

      pushed  = 0;
      drained = 1'b0;
      while (pushed < ITEMS_PER_PHASE) begin
        pushed += queue_burst(stop_level);
        // Half way through, hold the sender off until every decision is out.
        if (!drained && pushed >= ITEMS_PER_PHASE / 2) begin
          wait_quiet();
          drained = 1'b1;
        end
      end
      wait_quiet();
    end

    if (decision_fifo.size() != 0) begin
      report_mismatch("decisions never delivered", decision_fifo.size(), 0);
    end

    $display("Ran %0d stores and %0d evaluates over %0d threshold settings in %0d cycles.",
             store_count, eval_count, level_writes + 1, cycle_count);
    $display("Decisions seen: stop %0d, right %0d, left %0d, forward %0d; mismatches %0d.",
             drive_hits[DRIVE_STOP], drive_hits[DRIVE_RIGHT], drive_hits[DRIVE_LEFT],
             drive_hits[DRIVE_FORWARD], mismatch_count);
    if (mismatch_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
